/* rtl/sesi_pkg.sv */
`timescale 1ns / 1ps
package sesi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_DABS_DEF   = 64;
	localparam int LEFT_W         = 21;   // carried leftover, 1/16 px
	localparam int SPACING_W      = 16;
	localparam int SPACE16_W      = SPACING_W + 4;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd16;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} sesi_unit_stat_t;

endpackage

/* rtl/sesi_div.sv */
`timescale 1ns / 1ps
module sesi_div import sesi_pkg::*; #(
	parameter int NW = 45,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output sesi_unit_stat_t stat,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   shifted, diff;

	// one quotient bit a cycle, restoring
	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;
	assign rem       = rem_q;

endmodule

/* rtl/sesi_sqrt.sv */
`timescale 1ns / 1ps
module sesi_sqrt import sesi_pkg::*; #(
	parameter int RW = 21
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] rad,
	output sesi_unit_stat_t stat,
	output logic [RW-1:0]   root
);
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q, done_q;
	logic [RW+2:0]   r2, trial, diff;

	// digit by digit: two radicand bits in, one root bit out
	assign r2    = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = r2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[2*RW-3:0], 2'b00};
			if (r2 >= trial) begin
				rem_q  <= diff[RW:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= r2[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

/* rtl/stroke_equal_spacing_interpolator.sv */
`timescale 1ns / 1ps
// Brush dab interpolator: pen points in, dabs at equal arc spacing out.
// Input channel in_valid/in_ready carries one pen point per beat; output
// channel out_valid/out_ready carries one dab per beat. cfg_wr_en writes
// dab_spacing (whole px, 0 acts as 1) in the cycle it is high; write only
// while idle.
// A point that opens a stroke gives one dab, valid the cycle after accept.
// Any other point: the squared length on the shared multiplier, then the
// square root, the dab count on the shared divider, then per dab one
// multiply and one divider pass for each of x and y, plus the output beat.
// The divider (DDW = 56 bits at defaults) runs one quotient bit a cycle.
// One point is in work at a time: in_ready is high only when idle.
// Up to MAX_DABS_PER_POINT dabs per point; the rest are dropped and flagged.
// A stalled receiver holds the dab in the output register and the
// sequencer waits. Reset clears the held point, the leftover and spacing
// (back to 16), and leaves the block idle; in_ready stays low during reset
// and rises the cycle after it is released.
module stroke_equal_spacing_interpolator import sesi_pkg::*; #(
	parameter int MAX_DABS_PER_POINT = MAX_DABS_DEF,
	parameter int COORD_BITS         = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [SPACING_W-1:0]         cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [9:0]                   pen_pressure,
	input  logic                         new_stroke,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] dab_x,
	output logic signed [COORD_BITS-1:0] dab_y,
	output logic [9:0]                   dab_pressure,
	output logic                         last_of_run,
	output logic                         truncated
);
	localparam int CB   = COORD_BITS;
	localparam int DXW  = CB + 1;
	localparam int SQW  = 2 * CB + 2;
	localparam int RW   = CB + 5;
	localparam int EW   = $clog2(MAX_DABS_PER_POINT + 1);
	localparam int TW   = ((RW > LEFT_W) ? RW : LEFT_W) + 1;
	localparam int TTW  = (((SPACE16_W + EW) > LEFT_W) ? (SPACE16_W + EW) : LEFT_W) + 1;
	localparam int MBW  = (TTW > DXW) ? TTW : DXW;
	localparam int PW   = 2 * MBW;
	localparam int DDW  = (PW > TW) ? PW : TW;
	localparam int DVW  = (RW > SPACE16_W) ? RW : SPACE16_W;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SQX  = 10'b0000000010,
		S_SQY  = 10'b0000000100,
		S_ROOT = 10'b0000001000,
		S_CNT  = 10'b0000010000,
		S_MULX = 10'b0000100000,
		S_DIVX = 10'b0001000000,
		S_MULY = 10'b0010000000,
		S_DIVY = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic                  ready_q;
	logic [SPACING_W-1:0]  spacing_q;
	logic                  have_prev_q;
	logic signed [CB-1:0]  prev_x_q, prev_y_q, next_x_q, next_y_q;
	logic [9:0]            prev_p_q, next_p_q;
	logic [LEFT_W-1:0]     left_q;
	logic signed [DXW-1:0] dx_q, dy_q;
	logic [SQW-1:0]        acc_q;
	logic [RW-1:0]         len_q;
	logic [EW-1:0]         emit_q, n_q;
	logic                  trunc_q;
	logic signed [TTW-1:0] t_q;
	logic [PW-1:0]         mag_q;
	logic                  neg_q, go_q;
	logic                  out_valid_q, last_q, trunc_out_q;
	logic signed [CB-1:0]  dab_x_q, dab_y_q;
	logic [9:0]            dab_p_q;

	logic [SPACE16_W-1:0]  s16;
	logic signed [MBW-1:0] mul_a, mul_b;
	logic signed [PW-1:0]  mul_p;
	logic [SQW-1:0]        sq_sum;
	logic [TW-1:0]         total, cnt;
	logic [CB-1:0]         q_lo, q_sgn;
	logic                  accept, root_go, div_start;
	logic [DDW-1:0]        div_num;
	logic [DVW-1:0]        div_den;
	logic [DDW-1:0]        quot;
	logic [DVW-1:0]        rem;
	logic [RW-1:0]         root;
	sesi_unit_stat_t       div_stat, root_stat;

	assign s16    = {((spacing_q == '0) ? SPACING_W'(1) : spacing_q), 4'b0000};
	assign accept = in_valid && in_ready;

	// shared multiplier: squares, then dx*t and dy*t per dab
	always_comb begin
		mul_a = ((state_q == S_SQX) || (state_q == S_MULX)) ? MBW'(dx_q) : MBW'(dy_q);
		unique case (state_q)
			S_SQX:   mul_b = MBW'(dx_q);
			S_SQY:   mul_b = MBW'(dy_q);
			default: mul_b = MBW'(t_q);
		endcase
	end
	assign mul_p  = mul_a * mul_b;
	assign sq_sum = acc_q + mul_p[SQW-1:0];

	assign root_go = (state_q == S_ROOT) && root_stat.done && (root != '0);
	assign total   = TW'(root) + TW'(left_q);
	assign div_start = go_q || root_go;
	assign div_num = (state_q == S_ROOT) ? DDW'(total - TW'(1)) : DDW'(mag_q);
	assign div_den = (state_q == S_ROOT) ? DVW'(s16) : DVW'(len_q);
	assign cnt     = quot[TW-1:0];
	assign q_lo    = quot[CB-1:0];
	assign q_sgn   = neg_q ? (CB'(0) - q_lo) : q_lo;

	sesi_sqrt #(.RW(RW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQY),
		.rad    ({sq_sum, 8'h00}),
		.stat   (root_stat),
		.root   (root)
	);

	sesi_div #(.NW(DDW), .DW(DVW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quot   (quot),
		.rem    (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b0;
			spacing_q   <= SPACING_RESET;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_p_q    <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			go_q        <= 1'b0;
			emit_q      <= '0;
			n_q         <= '0;
		end else begin
			ready_q <= 1'b1;
			go_q    <= 1'b0;
			if (cfg_wr_en)
				spacing_q <= cfg_wr_data;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (new_stroke || !have_prev_q) begin
							have_prev_q <= 1'b1;
							prev_x_q    <= pos_x;
							prev_y_q    <= pos_y;
							prev_p_q    <= pen_pressure;
							left_q      <= '0;
							emit_q      <= EW'(1);
							n_q         <= EW'(1);
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_SQX;
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_stat.done) begin
						if (root == '0) begin
							prev_x_q <= next_x_q;
							prev_y_q <= next_y_q;
							prev_p_q <= next_p_q;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_CNT;
						end
					end
				end
				S_CNT: begin
					if (div_stat.done) begin
						left_q <= LEFT_W'(rem) + LEFT_W'(1);
						n_q    <= EW'(1);
						emit_q <= (cnt > TW'(MAX_DABS_PER_POINT)) ?
							EW'(MAX_DABS_PER_POINT) : cnt[EW-1:0];
						if (cnt == '0) begin
							prev_x_q <= next_x_q;
							prev_y_q <= next_y_q;
							prev_p_q <= next_p_q;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_MULX;
						end
					end
				end
				S_MULX: begin
					go_q    <= 1'b1;
					state_q <= S_DIVX;
				end
				S_DIVX: if (div_stat.done) state_q <= S_MULY;
				S_MULY: begin
					go_q    <= 1'b1;
					state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (div_stat.done) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (n_q == emit_q) begin
							prev_x_q <= next_x_q;
							prev_y_q <= next_y_q;
							prev_p_q <= next_p_q;
							state_q  <= S_IDLE;
						end else begin
							n_q     <= n_q + EW'(1);
							state_q <= S_MULX;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			next_x_q <= pos_x;
			next_y_q <= pos_y;
			next_p_q <= pen_pressure;
			dx_q     <= DXW'(pos_x) - DXW'(prev_x_q);
			dy_q     <= DXW'(pos_y) - DXW'(prev_y_q);
			dab_x_q  <= pos_x;
			dab_y_q  <= pos_y;
			dab_p_q  <= pen_pressure;
			last_q      <= 1'b1;
			trunc_out_q <= 1'b0;
		end
		if (state_q == S_SQX)
			acc_q <= mul_p[SQW-1:0];
		if (root_go)
			len_q <= root;
		if ((state_q == S_CNT) && div_stat.done) begin
			trunc_q <= cnt > TW'(MAX_DABS_PER_POINT);
			t_q     <= TTW'(s16) - TTW'(left_q);
		end
		if ((state_q == S_MULX) || (state_q == S_MULY)) begin
			neg_q <= mul_p[PW-1];
			mag_q <= mul_p[PW-1] ? (PW'(0) - mul_p) : mul_p;
		end
		if ((state_q == S_DIVX) && div_stat.done)
			dab_x_q <= prev_x_q + q_sgn;
		if ((state_q == S_DIVY) && div_stat.done) begin
			dab_y_q     <= prev_y_q + q_sgn;
			dab_p_q     <= prev_p_q;
			last_q      <= (n_q == emit_q);
			trunc_out_q <= trunc_q;
		end
		if ((state_q == S_OUT) && out_ready)
			t_q <= t_q + TTW'(s16);
	end

	assign in_ready     = ready_q && (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign dab_x        = dab_x_q;
	assign dab_y        = dab_y_q;
	assign dab_pressure = dab_p_q;
	assign last_of_run  = last_q;
	assign truncated    = trunc_out_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while dab pending");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_OUT)) else $error("dab shown outside output state");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider restarted while busy");
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> !in_ready)
		else $error("run ended before its last dab");

endmodule

/* tb/stroke_equal_spacing_interpolator_tb.sv */
`timescale 1ns / 1ps
module stroke_equal_spacing_interpolator_tb import sesi_pkg::*;;

	localparam int  CAP        = MAX_DABS_DEF;
	localparam int  IDLE_WAIT  = 300;
	localparam longint LIMIT   = 20000000;
	localparam int  LONG_HOLD  = 3000;
	localparam int  PER_PHASE  = 50;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [9:0]         p;
		logic               last;
		logic               trunc;
	} dab_t;

	typedef struct {
		bit                 do_cfg;
		bit [15:0]          cfg;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [9:0]         p;
		bit                 ns;
		bit                 typed;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic [9:0]         ep;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SPACING_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic [9:0] pen_pressure = '0;
	logic new_stroke = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] dab_x;
	logic signed [15:0] dab_y;
	logic [9:0] dab_pressure;
	logic last_of_run;
	logic truncated;

	// predictor state
	bit                 have_prev;
	logic signed [15:0] prev_x;
	logic signed [15:0] prev_y;
	logic [9:0]         prev_p;
	logic [20:0]        leftover;
	logic [15:0]        spacing;

	dab_t   dab_q[$];
	int     errors;
	longint cycles;
	bit     quiet;
	bit     hold_req;

	stroke_equal_spacing_interpolator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pen_pressure(pen_pressure),
		.new_stroke(new_stroke),
		.out_valid(out_valid), .out_ready(out_ready),
		.dab_x(dab_x), .dab_y(dab_y), .dab_pressure(dab_pressure),
		.last_of_run(last_of_run), .truncated(truncated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned sqrt_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void predict_dabs(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [9:0] p, input logic ns);
		longint dx, dy, len, s16, lft, total, c, emit, t, n;
		dab_t d;
		if (ns || !have_prev) begin
			d.x = x; d.y = y; d.p = p; d.last = 1'b1; d.trunc = 1'b0;
			dab_q = {dab_q, d};
			have_prev = 1'b1;
			prev_x = x; prev_y = y; prev_p = p;
			leftover = '0;
			return;
		end
		dx = longint'(x) - longint'(prev_x);
		dy = longint'(y) - longint'(prev_y);
		len = longint'(sqrt_floor(longint'(dx * dx + dy * dy) << 8));
		s16 = (spacing == 0 ? 1 : longint'(spacing)) * 16;
		lft = longint'(leftover);
		if (len != 0) begin
			total = len + lft;
			c = (total - 1) / s16;
			emit = c > CAP ? CAP : c;
			for (n = 1; n <= emit; n++) begin
				// signed division truncates toward zero, as the datapath does
				t = s16 * n - lft;
				d.x = 16'(longint'(prev_x) + (dx * t) / len);
				d.y = 16'(longint'(prev_y) + (dy * t) / len);
				d.p = prev_p;
				d.last = (n == emit);
				d.trunc = (c > CAP);
				dab_q = {dab_q, d};
			end
			leftover = 21'(total - s16 * c);
		end
		prev_x = x; prev_y = y; prev_p = p;
	endfunction

	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [9:0] p, input logic ns);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x; pos_y <= y; pen_pressure <= p; new_stroke <= ns;
		do @(posedge clk); while (!in_ready);
		predict_dabs(x, y, p, ns);
	endtask

	task automatic write_spacing(input logic [15:0] v);
		in_valid <= 1'b0;
		while (dab_q.size() != 0) @(posedge clk);
		// a point that yields no dab may still be in the square root / divider
		repeat (IDLE_WAIT) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		spacing = v;
	endtask

	// random strokes: mostly short well-formed polylines, some noise points
	task automatic run_strokes(input int count, input int step_max);
		int sent, pts, k, nx, ny, cx, cy;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				send_point(16'($urandom), 16'($urandom), 10'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)));
				sent++;
				continue;
			end
			cx = int'($signed(16'($urandom)));
			cy = int'($signed(16'($urandom)));
			send_point(16'(cx), 16'(cy), 10'($urandom_range(0, 1023)), 1'b1);
			sent++;
			pts = $urandom_range(2, 9);
			for (k = 0; k < pts && sent < count; k++) begin
				nx = cx + int'($urandom_range(0, 2 * step_max)) - step_max;
				ny = cy + int'($urandom_range(0, 2 * step_max)) - step_max;
				if (nx > 32767 || nx < -32768) nx = cx - (nx - cx);
				if (ny > 32767 || ny < -32768) ny = cy - (ny - cy);
				cx = nx; cy = ny;
				send_point(16'(cx), 16'(cy), 10'($urandom_range(0, 1023)), 1'b0);
				sent++;
			end
		end
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int stall;
		dab_t e;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (dab_q.size() == 0) begin
					$error("unexpected dab x=%0d y=%0d", dab_x, dab_y);
					errors++;
				end else begin
					e = dab_q.pop_front();
					if (dab_x !== e.x) begin
						$error("dab_x exp %0d got %0d", e.x, dab_x); errors++;
					end
					if (dab_y !== e.y) begin
						$error("dab_y exp %0d got %0d", e.y, dab_y); errors++;
					end
					if (dab_pressure !== e.p) begin
						$error("dab_pressure exp %0d got %0d", e.p, dab_pressure); errors++;
					end
					if (last_of_run !== e.last) begin
						$error("last_of_run exp %0b got %0b", e.last, last_of_run); errors++;
					end
					if (truncated !== e.trunc) begin
						$error("truncated exp %0b got %0b", e.trunc, truncated); errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end else if (stall == 0 && !quiet && arst_n && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		point_row_t rows[17];
		logic [15:0] phase_sp[7];
		int i;
		dab_t d;
		rows = '{
			// no point held yet: emitted as is even without new_stroke
			'{0, 0,      0,      0,    0, 0, 1,      0,      0,    0},
			'{0, 0,     80,      0,  100, 0, 0,      0,      0,    0},
			'{0, 0,     80,      0,  200, 0, 0,      0,      0,    0},
			'{0, 0, -32768,  32767, 1023, 1, 1, -32768,  32767, 1023},
			'{0, 0,  32767, -32768,    0, 0, 0,      0,      0,    0},
			'{0, 0,  32767, -32768,    5, 0, 0,      0,      0,    0},
			'{0, 0,    100,   -100,  512, 1, 1,    100,   -100,  512},
			'{0, 0,    103,    -96,  300, 0, 0,      0,      0,    0},
			'{0, 0,   -200,    300,    7, 0, 0,      0,      0,    0},
			// spacing lowered under the carried leftover: dabs behind start
			'{1, 1,   -195,    300,    9, 0, 0,      0,      0,    0},
			'{1, 200, -32000,    0,   50, 1, 1, -32000,      0,   50},
			'{0, 0, -32760,      0,   60, 0, 0,      0,      0,    0},
			// dabs behind the start run past the coordinate range and wrap
			'{1, 1, -32759,      0,   70, 0, 0,      0,      0,    0},
			'{1, 65535,  0,      0,    1, 1, 1,      0,      0,    1},
			'{0, 0,    300,    400,    2, 0, 0,      0,      0,    0},
			// spacing of zero acts as one
			'{1, 0,    301,    400,    3, 0, 0,      0,      0,    0},
			'{0, 0,    301,    420,    4, 0, 0,      0,      0,    0}
		};
		phase_sp = '{16'd3, 16'd65535, 16'd1, 16'd0, 16'd16, 16'd40, 16'd0};
		phase_sp[6] = 16'($urandom_range(2, 200));
		have_prev = 1'b0;
		prev_x = '0; prev_y = '0; prev_p = '0;
		leftover = '0;
		spacing = SPACING_RESET;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 17; i++) begin
			if (rows[i].do_cfg) write_spacing(rows[i].cfg);
			send_point(rows[i].x, rows[i].y, rows[i].p, rows[i].ns);
			if (rows[i].typed) begin
				d = dab_q.pop_back();
				d.x = rows[i].ex; d.y = rows[i].ey; d.p = rows[i].ep;
				d.last = 1'b1; d.trunc = 1'b0;
				dab_q = {dab_q, d};
			end
		end

		for (i = 0; i < 7; i++) begin
			write_spacing(phase_sp[i]);
			if (i == 0) hold_req = 1'b1;
			if (i == 6) quiet = 1'b1;
			run_strokes(PER_PHASE,
				phase_sp[i] == 0 ? 3 : (phase_sp[i] * 6 > 4000 ? 4000 : phase_sp[i] * 6));
		end
		in_valid <= 1'b0;

		while (dab_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/sesi_pkg.sv
rtl/sesi_div.sv
rtl/sesi_sqrt.sv
rtl/stroke_equal_spacing_interpolator.sv
tb/stroke_equal_spacing_interpolator_tb.sv
